// ----- rtl/rle_run_decoder_macros.svh -----
// Assertion macros shared by the run decoder modules.
`ifndef RLE_RUN_DECODER_MACROS_SVH
`define RLE_RUN_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define RRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define RRD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RRD_ASSERT_IMP(label, ante, cons, msg)
`define RRD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/rrd_pkg.sv -----
// Types, constants and helpers of the run-length run decoder.
package rrd_pkg;

  localparam logic [7:0]  TERMINATOR          = 8'h80;
  localparam logic [8:0]  REPEAT_BASE         = 9'd257;
  localparam logic [15:0] OUTPUT_LENGTH_RESET = 16'd14400;
  localparam logic [15:0] INPUT_LIMIT_RESET   = 16'hFFFF;
  localparam int          QUEUE_DEPTH         = 4;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_REPEAT  = 3'b010,
    PH_LITERAL = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_TERMINATOR  = 2'd0,
    ST_INPUT_LIMIT = 2'd1,
    ST_OUTPUT_FULL = 2'd2
  } status_t;

  typedef enum logic {
    CFG_OUTPUT_LENGTH = 1'b0,
    CFG_INPUT_LIMIT   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] run_length;
    logic        last;
    logic [1:0]  status;
    logic [15:0] consumed;
  } result_t;

  // Words produced by one accepted input word: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    item1;
    result_t    item0;
  } push_t;

  function automatic result_t make_item(logic [7:0] value, logic [15:0] run_length,
                                        logic last, status_t status,
                                        logic [15:0] consumed);
    result_t r;
    r.value      = value;
    r.run_length = run_length;
    r.last       = last;
    r.status     = status;
    r.consumed   = consumed;
    return r;
  endfunction

endpackage

// ----- rtl/rrd_channels.sv -----
// Valid/ready channel interfaces for compressed input and decoded runs.
interface rrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       first;

  modport source (output valid, output code_byte, output first, input ready);
  modport sink (input valid, input code_byte, input first, output ready);
endinterface

interface rrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value;
  logic [15:0] run_length;
  logic        last;
  logic [1:0]  status;
  logic [15:0] consumed;

  modport source (output valid, output value, output run_length, output last,
                  output status, output consumed, input ready);
  modport sink (input valid, input value, input run_length, input last,
                input status, input consumed, output ready);
endinterface

// ----- rtl/rrd_core.sv -----
// Decoder state, configuration registers and per-word decode logic.
`include "rle_run_decoder_macros.svh"

module rrd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             accept,
  input  logic [7:0]       code_byte,
  input  logic             first,
  output rrd_pkg::push_t   push
);

  logic [15:0]     out_len_r;
  logic [15:0]     in_lim_r;
  rrd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      count_r, count_nxt;
  logic [15:0]     out_pos_r, out_pos_nxt;
  logic [15:0]     in_pos_r, in_pos_nxt;
  logic [15:0]     pkt_r, pkt_nxt;
  logic            fin_r, fin_nxt;
  rrd_pkg::push_t  push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_len_r <= rrd_pkg::OUTPUT_LENGTH_RESET;
      in_lim_r  <= rrd_pkg::INPUT_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rrd_pkg::CFG_OUTPUT_LENGTH: out_len_r <= cfg_wdata;
        rrd_pkg::CFG_INPUT_LIMIT:   in_lim_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [15:0]    room;
    rrd_pkg::result_t item;
    logic           emit;
    logic           pend;

    phase_nxt   = phase_r;
    count_nxt   = count_r;
    out_pos_nxt = out_pos_r;
    in_pos_nxt  = in_pos_r;
    pkt_nxt     = pkt_r;
    fin_nxt     = fin_r;
    push_c      = '0;
    item        = '0;
    emit        = 1'b0;
    pend        = 1'b0;
    room        = '0;

    if (first) begin
      phase_nxt   = rrd_pkg::PH_HEADER;
      count_nxt   = '0;
      out_pos_nxt = '0;
      in_pos_nxt  = '0;
      pkt_nxt     = '0;
      fin_nxt     = 1'b0;
    end

    if (accept && !fin_nxt) begin
      room = (out_len_r > out_pos_nxt) ? out_len_r - out_pos_nxt : 16'd0;
      case (phase_nxt)
        rrd_pkg::PH_HEADER: begin
          pkt_nxt    = in_pos_nxt;
          in_pos_nxt = 16'(in_pos_nxt + 16'd1);
          if (code_byte == rrd_pkg::TERMINATOR) begin
            push_c.item0 = rrd_pkg::make_item(8'd0, room, 1'b1,
                                              rrd_pkg::ST_TERMINATOR, pkt_nxt);
            push_c.count = 2'd1;
            fin_nxt      = 1'b1;
          end else if (code_byte[7]) begin
            if (({1'b0, pkt_nxt} + 17'd1) >= {1'b0, in_lim_r}) begin
              push_c.item0 = rrd_pkg::make_item(8'd0, room, 1'b1,
                                                rrd_pkg::ST_INPUT_LIMIT, pkt_nxt);
              push_c.count = 2'd1;
              fin_nxt      = 1'b1;
            end else begin
              count_nxt = 8'(rrd_pkg::REPEAT_BASE - {1'b0, code_byte});
              phase_nxt = rrd_pkg::PH_REPEAT;
            end
          end else begin
            count_nxt = 8'({1'b0, code_byte} + 9'd1);
            // Literal check before the first literal byte is awaited.
            if (out_pos_nxt >= out_len_r) begin
              push_c.item0 = rrd_pkg::make_item(8'd0, 16'd0, 1'b1,
                                                rrd_pkg::ST_OUTPUT_FULL, pkt_nxt);
              push_c.count = 2'd1;
              fin_nxt      = 1'b1;
            end else if (in_pos_nxt >= in_lim_r) begin
              push_c.item0 = rrd_pkg::make_item(8'd0, room, 1'b1,
                                                rrd_pkg::ST_INPUT_LIMIT, pkt_nxt);
              push_c.count = 2'd1;
              fin_nxt      = 1'b1;
            end else begin
              phase_nxt = rrd_pkg::PH_LITERAL;
            end
          end
        end

        rrd_pkg::PH_REPEAT: begin
          if ({8'd0, count_nxt} > room) begin
            push_c.item0 = rrd_pkg::make_item(code_byte, room, 1'b1,
                                              rrd_pkg::ST_OUTPUT_FULL, pkt_nxt);
            push_c.count = 2'd1;
            fin_nxt      = 1'b1;
          end else begin
            push_c.item0 = rrd_pkg::make_item(code_byte, {8'd0, count_nxt}, 1'b0,
                                              rrd_pkg::ST_TERMINATOR, 16'd0);
            push_c.count = 2'd1;
            out_pos_nxt  = 16'(out_pos_nxt + {8'd0, count_nxt});
            count_nxt    = '0;
            in_pos_nxt   = 16'(in_pos_nxt + 16'd1);
            pend         = 1'b1;
          end
        end

        rrd_pkg::PH_LITERAL: begin
          push_c.item0 = rrd_pkg::make_item(code_byte, 16'd1, 1'b0,
                                            rrd_pkg::ST_TERMINATOR, 16'd0);
          push_c.count = 2'd1;
          out_pos_nxt  = 16'(out_pos_nxt + 16'd1);
          in_pos_nxt   = 16'(in_pos_nxt + 16'd1);
          count_nxt    = (count_nxt != 8'd0) ? 8'(count_nxt - 8'd1) : 8'd0;
          if (count_nxt == 8'd0) begin
            pend = 1'b1;
          end else if (out_pos_nxt >= out_len_r) begin
            item = rrd_pkg::make_item(8'd0, 16'd0, 1'b1,
                                      rrd_pkg::ST_OUTPUT_FULL, pkt_nxt);
            emit = 1'b1;
          end else if (in_pos_nxt >= in_lim_r) begin
            room = (out_len_r > out_pos_nxt) ? out_len_r - out_pos_nxt : 16'd0;
            item = rrd_pkg::make_item(8'd0, room, 1'b1,
                                      rrd_pkg::ST_INPUT_LIMIT, pkt_nxt);
            emit = 1'b1;
          end else begin
            phase_nxt = rrd_pkg::PH_LITERAL;
          end
        end

        default: begin
          phase_nxt = rrd_pkg::PH_HEADER;
        end
      endcase

      // End of a packet: the next header offset must still be inside the limit.
      if (pend) begin
        pkt_nxt = in_pos_nxt;
        if (pkt_nxt >= in_lim_r) begin
          room = (out_len_r > out_pos_nxt) ? out_len_r - out_pos_nxt : 16'd0;
          item = rrd_pkg::make_item(8'd0, room, 1'b1,
                                    rrd_pkg::ST_INPUT_LIMIT, pkt_nxt);
          emit = 1'b1;
        end else begin
          phase_nxt = rrd_pkg::PH_HEADER;
        end
      end

      if (emit) begin
        push_c.item1 = item;
        push_c.count = 2'd2;
        fin_nxt      = 1'b1;
      end
    end else if (!accept) begin
      phase_nxt   = phase_r;
      count_nxt   = count_r;
      out_pos_nxt = out_pos_r;
      in_pos_nxt  = in_pos_r;
      pkt_nxt     = pkt_r;
      fin_nxt     = fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rrd_pkg::PH_HEADER;
      count_r   <= '0;
      out_pos_r <= '0;
      in_pos_r  <= '0;
      pkt_r     <= '0;
      fin_r     <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      out_pos_r <= out_pos_nxt;
      in_pos_r  <= in_pos_nxt;
      pkt_r     <= pkt_nxt;
      fin_r     <= fin_nxt;
    end
  end

  assign push = push_c;

  `RRD_ASSERT_IMP(a_idle_no_push, !accept, push.count == 2'd0, "push without an accepted word")
  `RRD_ASSERT_IMP(a_done_silent, accept && fin_r && !first, push.count == 2'd0, "word after stream end produced a result")
  `RRD_ASSERT_IMP(a_header_single, accept && (first || phase_r == rrd_pkg::PH_HEADER), push.count != 2'd2, "header produced two results")
  `RRD_ASSERT_NXT(a_last_ends, push.count == 2'd2 || (push.count == 2'd1 && push.item0.last), fin_r, "stream not closed after last word")

endmodule

// ----- rtl/rrd_queue.sv -----
// Shift-down result queue taking up to two words per cycle.
`include "rle_run_decoder_macros.svh"

module rrd_queue #(
  parameter int DEPTH = rrd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rrd_pkg::push_t   push,
  output logic             has_room,
  output logic             head_valid,
  output rrd_pkg::result_t head,
  input  logic             pop
);

  localparam int CW = $clog2(DEPTH + 1);

  rrd_pkg::result_t q_r [DEPTH];
  rrd_pkg::result_t q_nxt [DEPTH];
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    base;
  logic             do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign base       = do_pop ? CW'(count_r - CW'(1)) : count_r;
  assign count_nxt  = CW'(base + CW'(push.count));
  assign has_room   = count_r <= CW'(DEPTH - 2);
  assign head_valid = count_r != '0;
  assign head       = q_r[0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_nxt[i] = q_r[i];
      if (do_pop && (i < DEPTH - 1)) begin
        q_nxt[i] = q_r[i + 1];
      end
      if ((CW'(i) == base) && (push.count != 2'd0)) begin
        q_nxt[i] = push.item0;
      end
      if ((CW'(i) == CW'(base + CW'(1))) && (push.count == 2'd2)) begin
        q_nxt[i] = push.item1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  `RRD_ASSERT_IMP(a_bound, 1'b1, count_r <= CW'(DEPTH), "queue count beyond depth")
  `RRD_ASSERT_IMP(a_no_overflow, push.count != 2'd0, count_r <= CW'(DEPTH - 2), "push into a full queue")
  `RRD_ASSERT_NXT(a_drain, do_pop && count_r == CW'(1) && push.count == 2'd0, !head_valid, "queue not empty after last pop")

endmodule

// ----- rtl/rle_run_decoder.sv -----
// Top level of the PackBits-style run decoder with its configuration port.
//
// Decodes a PackBits-style compressed stream, one word (byte) per input
// handshake, into run words of (value, run_length). A word with first set
// starts a new stream. Header 0x80 ends the stream with one zero-fill run;
// a header with the top bit set repeats the next byte 257 minus header
// times; any other header copies header+1 literal bytes, one run word each.
// The word that ends a stream has last set and carries the status
// (terminator, input limit, output full) and the input offset of the
// unfinished packet. Input words after the end give nothing until first.
// Each input word is decoded in the cycle it is accepted and yields zero,
// one or two run words, which go into a four-entry result queue; the head
// of that queue drives the output channel. The block takes one input word
// every clock cycle as long as the queue holds at most two words, so with
// a sink that is always ready it runs at one word per cycle; the output
// port, moving one word per cycle, is the only thing that can slow it.
// Run words are registered in the result queue before they reach the output. The two
// configuration registers (output_length at index 0, input_limit at
// index 1) are written through cfg_we / cfg_index / cfg_wdata and should
// only be changed while no stream word is in flight.
module rle_run_decoder #(
  parameter int QUEUE_DEPTH = rrd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  rrd_in_if.sink      in_bus,
  rrd_out_if.source   out_bus
);

  rrd_pkg::push_t   push;
  rrd_pkg::result_t head;
  logic             has_room;
  logic             head_valid;
  logic             accept;

  // Ready only depends on queue room, never on the decoder state.
  assign in_bus.ready = has_room;
  assign accept       = in_bus.valid && has_room;

  rrd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .code_byte (in_bus.code_byte),
    .first     (in_bus.first),
    .push      (push)
  );

  rrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .has_room   (has_room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_bus.ready)
  );

  assign out_bus.valid      = head_valid;
  assign out_bus.value      = head.value;
  assign out_bus.run_length = head.run_length;
  assign out_bus.last       = head.last;
  assign out_bus.status     = head.status;
  assign out_bus.consumed   = head.consumed;

endmodule

// ----- sim/rle_run_decoder_checker.sv -----
// Checker that predicts the decoder's run words and compares them with the output channel.
module rle_run_decoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  rrd_in_if           in_mon,
  rrd_out_if          out_mon,
  output int          errors,
  output int          pending,
  output int          live_words,
  output int          runs_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrd_pkg::*;

  // Words that do not end a stream carry a zero status.
  localparam logic [1:0] STATUS_NONE = 2'd0;

  logic [15:0] out_len;
  logic [15:0] in_lim;

  phase_t      phase;
  logic [7:0]  count_left;
  logic [15:0] out_pos;
  logic [15:0] in_pos;
  logic [15:0] pkt_start;
  logic        finished;

  result_t     runs_due[$];
  result_t     want_run;
  result_t     got_run;
  int          shown;

  function automatic logic [15:0] room_left();
    return (out_len > out_pos) ? out_len - out_pos : 16'd0;
  endfunction

  function automatic void queue_run(logic [7:0] v, logic [15:0] len, logic last,
                                    logic [1:0] st, logic [15:0] cons);
    result_t r;
    r.value      = v;
    r.run_length = len;
    r.last       = last;
    r.status     = st;
    r.consumed   = cons;
    runs_due.push_back(r);
  endfunction

  function automatic void close_with_fill(status_t st);
    queue_run(8'd0, room_left(), 1'b1, st, pkt_start);
    finished = 1'b1;
  endfunction

  // Done before every literal byte is awaited.
  function automatic void check_literal_room();
    if (out_pos >= out_len) begin
      queue_run(8'd0, 16'd0, 1'b1, ST_OUTPUT_FULL, pkt_start);
      finished = 1'b1;
    end else if (in_pos >= in_lim) begin
      close_with_fill(ST_INPUT_LIMIT);
    end else begin
      phase = PH_LITERAL;
    end
  endfunction

  function automatic void finish_packet();
    pkt_start = in_pos;
    if (pkt_start >= in_lim) begin
      close_with_fill(ST_INPUT_LIMIT);
    end else begin
      phase = PH_HEADER;
    end
  endfunction

  function automatic void decode_word(logic [7:0] b, logic f);
    logic [15:0] avail;
    if (f) begin
      phase      = PH_HEADER;
      count_left = 8'd0;
      out_pos    = 16'd0;
      in_pos     = 16'd0;
      pkt_start  = 16'd0;
      finished   = 1'b0;
    end else if (finished) begin
      return;
    end
    case (phase)
      PH_HEADER: begin
        pkt_start = in_pos;
        in_pos    = in_pos + 16'd1;
        if (b == TERMINATOR) begin
          close_with_fill(ST_TERMINATOR);
        end else if (b[7]) begin
          if ({1'b0, pkt_start} + 17'd1 >= {1'b0, in_lim}) begin
            close_with_fill(ST_INPUT_LIMIT);
          end else begin
            count_left = 8'(REPEAT_BASE - {1'b0, b});
            phase      = PH_REPEAT;
          end
        end else begin
          count_left = b + 8'd1;
          check_literal_room();
        end
      end
      PH_REPEAT: begin
        avail = room_left();
        if ({8'd0, count_left} > avail) begin
          queue_run(b, avail, 1'b1, ST_OUTPUT_FULL, pkt_start);
          finished = 1'b1;
        end else begin
          queue_run(b, {8'd0, count_left}, 1'b0, STATUS_NONE, 16'd0);
          out_pos    = out_pos + {8'd0, count_left};
          count_left = 8'd0;
          in_pos     = in_pos + 16'd1;
          finish_packet();
        end
      end
      default: begin
        queue_run(b, 16'd1, 1'b0, STATUS_NONE, 16'd0);
        out_pos = out_pos + 16'd1;
        in_pos  = in_pos + 16'd1;
        if (count_left > 8'd0) count_left = count_left - 8'd1;
        if (count_left == 8'd0) begin
          finish_packet();
        end else begin
          check_literal_room();
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_len      = OUTPUT_LENGTH_RESET;
      in_lim       = INPUT_LIMIT_RESET;
      phase        = PH_HEADER;
      count_left   = 8'd0;
      out_pos      = 16'd0;
      in_pos       = 16'd0;
      pkt_start    = 16'd0;
      finished     = 1'b1;
      runs_due.delete();
      errors       = 0;
      shown        = 0;
      live_words   = 0;
      runs_checked = 0;
    end else begin
      // A run word can never stem from an input word taken at the same edge,
      // so the output side is checked first.
      if (out_mon.valid && out_mon.ready) begin
        got_run.value      = out_mon.value;
        got_run.run_length = out_mon.run_length;
        got_run.last       = out_mon.last;
        got_run.status     = out_mon.status;
        got_run.consumed   = out_mon.consumed;
        if (runs_due.size() == 0) begin
          errors++;
          if (shown < 10) begin
            $display("unexpected run word: value %02h len %0d last %0b status %0d consumed %0d",
                     got_run.value, got_run.run_length, got_run.last, got_run.status,
                     got_run.consumed);
            shown++;
          end
        end else begin
          want_run = runs_due.pop_front();
          if (got_run != want_run) begin
            errors++;
            if (shown < 10) begin
              $display("run word %0d mismatch: expected value %02h len %0d last %0b %s %0d %s %0d,",
                       runs_checked, want_run.value, want_run.run_length, want_run.last,
                       "status", want_run.status, "consumed", want_run.consumed);
              $display("  got value %02h len %0d last %0b status %0d consumed %0d",
                       got_run.value, got_run.run_length, got_run.last, got_run.status,
                       got_run.consumed);
              shown++;
            end
          end
          runs_checked++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_OUTPUT_LENGTH) begin
          out_len = cfg_wdata;
        end else begin
          in_lim = cfg_wdata;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.first || !finished) live_words++;
        decode_word(in_mon.code_byte, in_mon.first);
      end
    end
    pending = runs_due.size();
  end

endmodule

// ----- sim/rle_run_decoder_test.sv -----
// Testbench top for the run decoder: stimulus, handshake timing, watchdog and verdict.
module rle_run_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rrd_pkg::*;

  // Input words sent, ignored ones included, after which the random part stops.
  localparam int TARGET_WORDS  = 1650;
  // Cycles without any handshake or register write before the run is abandoned.
  localparam int IDLE_LIMIT    = 2000;
  // Quiet cycles before a register write, so that a word that produced
  // nothing has also been taken in by the decoder.
  localparam int SETTLE_CYCLES = 4;
  // Quiet cycles at the end, to catch stray run words.
  localparam int TAIL_CYCLES   = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  rrd_in_if  in_bus ();
  rrd_out_if out_bus ();

  int errors;
  int pending;
  int live_words;
  int runs_checked;

  int idle_cycles   = 0;
  int in_stretch    = 0;
  int out_stretch   = 0;
  int streams       = 0;
  int settings_used = 0;
  int sent_words    = 0;
  bit start_flag;

  rle_run_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  rle_run_decoder_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .errors       (errors),
    .pending      (pending),
    .live_words   (live_words),
    .runs_checked (runs_checked)
  );

  // 4 ns clock, rising edges at 2 ns, 6 ns, ...
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The watchdog restarts whenever anything moves: a word on either channel
  // or a register write. A hung handshake therefore ends the run quickly.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d run words still due",
               IDLE_LIMIT, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Each side draws its wait per word. Now and then a stretch of words
  // goes through with no waits at all, so back-to-back traffic is covered.
  function automatic int draw_wait(inout int stretch);
    if (stretch > 0) begin
      stretch--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      stretch = $urandom_range(8, 60);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Sends one word. Entered and left at a falling edge; valid is left high
  // so that a following word with no gap goes out back to back.
  task automatic send_word(input logic [7:0] b, input logic f);
    int gap;
    gap = draw_wait(in_stretch);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.code_byte <= b;
    in_bus.first     <= f;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    sent_words++;
    @(negedge clk);
  endtask

  // Sends a word of the current stream; the first one carries the first flag.
  task automatic send_code(input logic [7:0] b);
    send_word(b, start_flag);
    start_flag = 1'b0;
  endtask

  // Holds the sender off until every predicted run word has come out.
  task automatic wait_for_runs();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Writes both registers once the block has gone quiet.
  task automatic configure(input logic [15:0] out_len, input logic [15:0] in_lim);
    wait_for_runs();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OUTPUT_LENGTH;
    cfg_wdata <= out_len;
    @(negedge clk);
    cfg_index <= CFG_INPUT_LIMIT;
    cfg_wdata <= in_lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One random stream: a few well-formed packets with random content, then
  // mostly a terminator and the zeroed byte behind it. Some streams are cut
  // off inside a literal, end in noise (which may restart a stream), or are
  // simply abandoned for the next one.
  task automatic gen_stream();
    int packets;
    int ending;
    int len;
    streams++;
    start_flag = 1'b1;
    packets = $urandom_range(0, 6);
    for (int p = 0; p < packets; p++) begin
      if ($urandom_range(0, 24) == 0) wait_for_runs();
      if ($urandom_range(0, 1) == 1) begin
        send_code(8'($urandom_range(8'h81, 8'hFF)));
        send_code(8'($urandom));
      end else begin
        // Mostly short literals; a long one now and then.
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
        send_code(8'(len));
        for (int i = 0; i <= len; i++) send_code(8'($urandom));
      end
    end
    ending = $urandom_range(0, 9);
    if (ending <= 6 || (packets == 0 && ending == 9)) begin
      send_code(TERMINATOR);
      send_code(8'h00);
    end else if (ending == 7) begin
      send_code(8'($urandom_range(2, 127)));
      send_code(8'($urandom));
    end else if (ending == 8) begin
      repeat ($urandom_range(1, 6)) begin
        send_word(8'($urandom), start_flag | ($urandom_range(0, 7) == 0));
        start_flag = 1'b0;
      end
    end
  endtask

  // The receiver draws a stall before each run word and then holds ready
  // high until a word has been taken.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = draw_wait(out_stretch);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  initial begin
    logic [15:0] out_len;
    logic [15:0] in_lim;
    int          phase_idx;

    // Every input is known from time zero.
    in_bus.valid     = 1'b0;
    in_bus.code_byte = 8'h00;
    in_bus.first     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_OUTPUT_LENGTH;
    cfg_wdata        = 16'd0;
    rst_n            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, first with a six-byte output and a ten-byte input limit.
    configure(16'd6, 16'd10);
    // A terminator right away fills the whole output; the zeroed byte after
    // it is ignored.
    send_word(8'h80, 1'b1); send_word(8'h00, 1'b0);
    // Repeat of three, a two-byte literal, then a repeat of four that is
    // clipped to the one byte of room left.
    send_word(8'hFE, 1'b1); send_word(8'hAA, 1'b0);
    send_word(8'h01, 1'b0); send_word(8'h11, 1'b0); send_word(8'h22, 1'b0);
    send_word(8'hFD, 1'b0); send_word(8'h55, 1'b0);
    // Literal of four with the byte extremes and the terminator value as
    // data, then a literal that fills the output before its last byte.
    send_word(8'h03, 1'b1); send_word(8'h00, 1'b0); send_word(8'hFF, 1'b0);
    send_word(8'h7F, 1'b0); send_word(8'h80, 1'b0);
    send_word(8'h02, 1'b0); send_word(8'h01, 1'b0); send_word(8'h02, 1'b0);

    // Now a full-size output and an input limit of three bytes.
    configure(16'hFFFF, 16'd3);
    // The limit is reached while literal bytes are still awaited.
    send_word(8'h05, 1'b1); send_word(8'h31, 1'b0); send_word(8'h32, 1'b0);
    // Longest repeat, then a repeat header whose byte would lie past the limit.
    send_word(8'h81, 1'b1); send_word(8'h42, 1'b0); send_word(8'hC0, 1'b0);
    // A packet that ends exactly at the limit.
    send_word(8'h01, 1'b1); send_word(8'h61, 1'b0); send_word(8'h62, 1'b0);

    // Random part: register settings rotate through the extremes and random
    // small values, with a handful of streams under each.
    phase_idx = 0;
    while (sent_words < TARGET_WORDS) begin
      case (phase_idx % 8)
        0: begin out_len = 16'd1;               in_lim = 16'hFFFF; end
        1: begin out_len = 16'hFFFF;            in_lim = 16'd1; end
        2: begin out_len = 16'hFFFF;            in_lim = 16'hFFFF; end
        3: begin out_len = 16'd1;               in_lim = 16'd1; end
        4: begin out_len = OUTPUT_LENGTH_RESET; in_lim = INPUT_LIMIT_RESET; end
        5: begin out_len = 16'($urandom_range(1, 24)); in_lim = 16'hFFFF; end
        6: begin out_len = 16'hFFFF;            in_lim = 16'($urandom_range(1, 40)); end
        default: begin
          out_len = 16'($urandom_range(1, 64));
          in_lim  = 16'($urandom_range(1, 64));
        end
      endcase
      configure(out_len, in_lim);
      repeat ($urandom_range(4, 12)) gen_stream();
      phase_idx++;
    end

    wait_for_runs();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending != 0) $display("%0d expected run words never arrived", pending);
    $display("Covered %0d streams under %0d register settings: %0d input words sent, %0d decoded,",
             streams, settings_used, sent_words, live_words);
    $display("  %0d run words checked, %0d failures.", runs_checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
